/* design/tkos_pkg.sv */
// Shared constants and types for the streaming top-k order statistics block.
package tkos_pkg;

  localparam int DATA_W           = 32;
  localparam int CMD_W            = 2;
  localparam int RANK_W           = 7;
  localparam int KEEP_W           = 7;
  localparam int CAPACITY_DEFAULT = 64;
  localparam int KEEP_RESET       = 64;

  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANK  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [RANK_W-1:0]        rank_t;
  typedef logic [KEEP_W-1:0]        keep_t;

endpackage

/* design/tkos_if.sv */
// Stream and configuration channel interfaces of the top-k block.
interface tkos_in_if;
  logic            valid;
  logic            ready;
  tkos_pkg::cmd_t  command;
  tkos_pkg::data_t sample;
  tkos_pkg::rank_t rank;

  modport source (output valid, output command, output sample, output rank, input ready);
  modport sink   (input valid, input command, input sample, input rank, output ready);
endinterface

interface tkos_out_if;
  logic            valid;
  logic            ready;
  tkos_pkg::data_t high_value;
  tkos_pkg::data_t low_value;
  logic            empty_res;
  logic            last;

  modport source (output valid, output high_value, output low_value, output empty_res,
                  output last, input ready);
  modport sink   (input valid, input high_value, input low_value, input empty_res,
                  input last, output ready);
endinterface

interface tkos_cfg_if;
  logic            valid;
  logic            ready;
  tkos_pkg::keep_t keep_count;

  modport source (output valid, output keep_count, input ready);
  modport sink   (input valid, input keep_count, output ready);
endinterface

/* design/tkos_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tkos_ram #(
  parameter int WIDTH = tkos_pkg::DATA_W,
  parameter int DEPTH = tkos_pkg::CAPACITY_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/streaming_top_k_order_statistics.sv */
// Top level of the streaming top-k order statistics block.
//
// Samples arrive on the samples channel with a command: offer a sample, drain
// every kept pair, or ask for a rank. Results leave on the results channel,
// one transaction per result, through an output register; the block takes
// its next input while that register still waits for the receiver.
// An offer walks each sorted set with one shared signed comparator over one
// RAM per set with registered read: one entry is shifted per cycle, and the
// block stays busy through that insertion walk after the offer's transaction.
// A rank query passes its pair from the registered RAM read into the output
// register, a drain emits one kept pair per cycle while the receiver takes
// them, and a stalled receiver simply holds the block in its emit step.
// The block accepts one input transaction at a time and is not ready while it
// works on one. The configuration channel is always ready; keep_count is
// taken only while the store is empty and is saturated to 1..CAPACITY.
// Synchronous reset empties the store and sets keep_count to its reset
// value; the set memories are not cleared, as only kept entries are read.
module streaming_top_k_order_statistics #(
  parameter int CAPACITY = tkos_pkg::CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  tkos_in_if.sink    samples,
  tkos_out_if.source results,
  tkos_cfg_if.sink   cfg
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = tkos_pkg::KEEP_W;
  localparam logic [KW-1:0] CAP_K   = KW'(CAPACITY);
  localparam logic [CW-1:0] KEEP_RV = CW'((tkos_pkg::KEEP_RESET < CAPACITY) ?
                                          tkos_pkg::KEEP_RESET : CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_GATE  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]      state;
  logic            sel;        // 0: largest set, 1: smallest set
  logic            grow;
  logic [AW-1:0]   i;
  logic [AW-1:0]   i_top;
  logic [AW-1:0]   idx;
  logic            is_drain;
  logic            is_empty;
  logic [CW-1:0]   kept;
  logic [CW-1:0]   keep;
  tkos_pkg::data_t samp;

  logic            out_valid;
  tkos_pkg::data_t out_high;
  tkos_pkg::data_t out_low;
  logic            out_empty;
  logic            out_last;

  logic            re;
  logic [AW-1:0]   raddr;
  logic            we;
  tkos_pkg::data_t wdata;
  tkos_pkg::data_t rd_h;
  tkos_pkg::data_t rd_l;
  tkos_pkg::data_t d;
  logic            win;
  logic            accept;
  logic            load;
  logic            last_item;
  logic [KW-1:0]   rank_sat;
  logic [AW-1:0]   rank_addr;
  logic [KW-1:0]   cfg_sat;
  logic            grow_in;
  logic [AW-1:0]   i_in;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  // Shared comparator: the sample beats the stored entry in the current set.
  assign d   = sel ? rd_l : rd_h;
  assign win = sel ? (samp < d) : (samp > d);

  assign load      = (state == S_EMIT) && (!out_valid || results.ready);
  assign last_item = !is_drain || (idx == '0);

  always_comb begin
    rank_sat = (samples.rank == '0) ? KW'(1) : samples.rank;
    if (rank_sat > KW'(kept)) begin
      rank_sat = KW'(kept);
    end
    rank_addr = AW'(rank_sat - KW'(1));
  end

  always_comb begin
    cfg_sat = (cfg.keep_count == '0) ? KW'(1) : cfg.keep_count;
    if (cfg_sat > CAP_K) begin
      cfg_sat = CAP_K;
    end
  end

  assign grow_in = (kept < keep);
  assign i_in    = grow_in ? AW'(kept) : AW'(kept - CW'(1));

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    we    = 1'b0;
    wdata = samp;
    case (state)
      S_IDLE: begin
        if (accept && kept != '0) begin
          if (samples.command == tkos_pkg::CMD_DRAIN) begin
            re    = 1'b1;
            raddr = AW'(kept - CW'(1));
          end else if (samples.command == tkos_pkg::CMD_RANK) begin
            re    = 1'b1;
            raddr = rank_addr;
          end
        end
      end
      S_START: begin
        if (!grow) begin
          re    = 1'b1;
          raddr = i_top;
        end else if (i_top != '0) begin
          re    = 1'b1;
          raddr = i_top - AW'(1);
        end
      end
      S_GATE: begin
        if (win && i != '0) begin
          re    = 1'b1;
          raddr = i - AW'(1);
        end
      end
      S_SHIFT: begin
        if (win) begin
          we    = 1'b1;
          wdata = d;
          if (i != AW'(1)) begin
            re    = 1'b1;
            raddr = i - AW'(2);
          end
        end
      end
      S_PUT: begin
        we = 1'b1;
      end
      S_EMIT: begin
        if (load && !last_item) begin
          re    = 1'b1;
          raddr = idx - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  tkos_ram #(.WIDTH(tkos_pkg::DATA_W), .DEPTH(CAPACITY)) u_high_ram (
    .clk   (clk),
    .we    (we && !sel),
    .waddr (i),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_h)
  );

  tkos_ram #(.WIDTH(tkos_pkg::DATA_W), .DEPTH(CAPACITY)) u_low_ram (
    .clk   (clk),
    .we    (we && sel),
    .waddr (i),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_l)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kept      <= '0;
      keep      <= KEEP_RV;
      out_valid <= 1'b0;
      sel       <= 1'b0;
      grow      <= 1'b0;
      is_drain  <= 1'b0;
      is_empty  <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && kept == '0) begin
        keep <= CW'(cfg_sat);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            samp <= samples.sample;
            case (samples.command)
              tkos_pkg::CMD_OFFER: begin
                sel   <= 1'b0;
                grow  <= grow_in;
                i_top <= i_in;
                if (grow_in) begin
                  kept <= kept + CW'(1);
                end
                state <= S_START;
              end
              tkos_pkg::CMD_DRAIN: begin
                if (kept != '0) begin
                  is_drain <= 1'b1;
                  is_empty <= 1'b0;
                  idx      <= AW'(kept - CW'(1));
                  state    <= S_EMIT;
                end
              end
              tkos_pkg::CMD_RANK: begin
                is_drain <= 1'b0;
                is_empty <= (kept == '0);
                state    <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_START: begin
          i <= i_top;
          if (!grow) begin
            state <= S_GATE;
          end else if (i_top != '0) begin
            state <= S_SHIFT;
          end else begin
            state <= S_PUT;
          end
        end
        S_GATE: begin
          if (!win) begin
            if (sel) begin
              state <= S_IDLE;
            end else begin
              sel   <= 1'b1;
              state <= S_START;
            end
          end else if (i != '0) begin
            state <= S_SHIFT;
          end else begin
            state <= S_PUT;
          end
        end
        S_SHIFT: begin
          if (win) begin
            i <= i - AW'(1);
            if (i == AW'(1)) begin
              state <= S_PUT;
            end
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (sel) begin
            state <= S_IDLE;
          end else begin
            sel   <= 1'b1;
            state <= S_START;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_valid <= 1'b1;
            out_high  <= is_empty ? '0 : rd_h;
            out_low   <= is_empty ? '0 : rd_l;
            out_empty <= is_empty;
            out_last  <= last_item;
            if (last_item) begin
              if (is_drain) begin
                kept <= '0;
              end
              state <= S_IDLE;
            end else begin
              idx <= idx - AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid      = out_valid;
  assign results.high_value = out_high;
  assign results.low_value  = out_low;
  assign results.empty_res  = out_empty;
  assign results.last       = out_last;

endmodule

/* design/tkos_checker.sv */
// Port-level checker for the top-k block, bound to the top level.
module tkos_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input tkos_pkg::data_t high_value,
  input tkos_pkg::data_t low_value,
  input logic            empty_res,
  input logic            last
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(high_value) && $stable(low_value) &&
                                $stable(empty_res) && $stable(last))
    else $error("result payload changed while stalled");

  // An empty-store answer carries zero values and closes its transaction.
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> high_value == '0 && low_value == '0 && last)
    else $error("empty result malformed");

  // The block only becomes busy by accepting a transaction.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> in_ready)
    else $error("input ready dropped without a transaction");

endmodule

bind streaming_top_k_order_statistics tkos_checker u_tkos_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .high_value (results.high_value),
  .low_value  (results.low_value),
  .empty_res  (results.empty_res),
  .last       (results.last)
);
